// ===== design/rse_pkg.sv =====
package rse_pkg;

	localparam int MEM_WORDS = 4096;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int NUM_OPS   = 10;
	localparam int OPC_W     = $clog2(NUM_OPS);
	localparam int PC_W      = 12;
	localparam int PL_W      = 13;
	localparam logic [4:0] ZERO_REG = 5'd31;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_ADDI  = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_BEQ   = 4'd4,
		OP_BNE   = 4'd5,
		OP_SLT   = 4'd6,
		OP_J     = 4'd7,
		OP_LW    = 4'd8,
		OP_SW    = 4'd9,
		OP_LABEL = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_WRITE = 2'd1,
		ST_NO_LABEL   = 2'd2,
		ST_BAD_MEM    = 2'd3
	} status_t;

	// decoded instruction as it travels from the front to the back
	typedef struct packed {
		op_t             op;
		logic            known_op;
		logic            writes_reg;
		logic            is_br;
		logic            is_j;
		logic            is_mem;
		logic [4:0]      rd;
		logic [4:0]      rs;
		logic [4:0]      rb;
		logic [31:0]     imm;
		logic            use_reg;
		logic [PC_W-1:0] target;
		logic            known;
	} dec_t;

	typedef struct packed {
		status_t         status;
		logic [PC_W-1:0] next_pc;
		logic [31:0]     write_value;
		logic [31:0]     cycle_total;
	} res_t;

endpackage

// ===== design/risc_subset_execute_unit.sv =====
// Execute unit for a small register/memory instruction subset.
// Input channel: one decoded instruction word per push while full is low.
// Result channel: one word per instruction (status, next_pc, write_value,
// cycle_total), oldest first while empty is low, taken by pop.
// APB port: register 0 at byte address 0 holds program_length; reads
// return it, pready is always high. Write it only while the unit is idle.
// A pushed word passes the decode queue, the execute register and the
// result queue; a valid lw also waits in execute for its data store read.
// Throughput: one word per cycle unless execute stalls; a valid lw holds
// execute for its data store read. Register operands are read as a word
// enters execute, bypassed from the word that commits in the same cycle.
// Reset: registers and counters clear at once; the data store is then
// zeroed one word per cycle, all 4096 words, with full held high.
// A two-word queue sits between decode and execute and another on the
// results; if pop stays low, execute stops when the result queue fills and
// full rises once the decode queue is also full.
module risc_subset_execute_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         op,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src_reg,
	input  logic [4:0]         third_reg,
	input  logic signed [31:0] immediate,
	input  logic               use_register,
	input  logic [11:0]        target_index,
	input  logic               target_known,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic [11:0]        next_pc,
	output logic signed [31:0] write_value,
	output logic [31:0]        cycle_total
);
	import rse_pkg::*;

	logic [PL_W-1:0] pl_q;
	logic            clearing;
	logic            head_valid;
	dec_t            head;
	logic            deq;
	logic            res_full;
	logic            res_wr;
	res_t            res;
	res_t            dout;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : 32'(pl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q <= '0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			pl_q <= pwdata[PL_W-1:0];
		end
	end

	rse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold         (clearing),
		.push         (push),
		.full         (full),
		.op           (op),
		.dest_reg     (dest_reg),
		.src_reg      (src_reg),
		.third_reg    (third_reg),
		.immediate    (immediate),
		.use_register (use_register),
		.target_index (target_index),
		.target_known (target_known),
		.deq          (deq),
		.head_valid   (head_valid),
		.head         (head)
	);

	rse_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.program_length (pl_q),
		.head_valid     (head_valid),
		.head           (head),
		.deq            (deq),
		.clearing       (clearing),
		.res_full       (res_full),
		.res_wr         (res_wr),
		.res            (res)
	);

	rse_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (dout)
	);

	assign status      = dout.status;
	assign next_pc     = dout.next_pc;
	assign write_value = dout.write_value;
	assign cycle_total = dout.cycle_total;

endmodule

// ===== design/rse_front.sv =====
module rse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hold,
	input  logic                push,
	output logic                full,
	input  logic [3:0]          op,
	input  logic [4:0]          dest_reg,
	input  logic [4:0]          src_reg,
	input  logic [4:0]          third_reg,
	input  logic signed [31:0]  immediate,
	input  logic                use_register,
	input  logic [11:0]         target_index,
	input  logic                target_known,
	input  logic                deq,
	output logic                head_valid,
	output rse_pkg::dec_t       head
);
	import rse_pkg::*;

	dec_t       dec;
	dec_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       enq;

	always_comb begin
		dec            = '0;
		dec.op         = op_t'(op);
		dec.rd         = dest_reg;
		dec.rs         = src_reg;
		dec.imm        = immediate;
		dec.use_reg    = use_register;
		dec.target     = target_index;
		dec.known      = target_known;
		dec.known_op   = 1'b1;
		unique case (op_t'(op))
			OP_ADD, OP_ADDI, OP_SUB, OP_MUL, OP_SLT: dec.writes_reg = 1'b1;
			OP_LW: begin
				dec.writes_reg = 1'b1;
				dec.is_mem     = 1'b1;
			end
			OP_SW:          dec.is_mem = 1'b1;
			OP_BEQ, OP_BNE: dec.is_br  = 1'b1;
			OP_J:           dec.is_j   = 1'b1;
			OP_LABEL:       dec.known_op = 1'b1;
			default:        dec.known_op = 1'b0;
		endcase
		// second read port: compare/store source, else second operand
		dec.rb = (dec.is_br || dec.op == OP_SW) ? dest_reg : third_reg;
	end

	assign full       = hold || (cnt_q == 2'd2);
	assign enq        = push && !full;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) wr_ptr_q <= !wr_ptr_q;
			if (deq) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(enq) - 2'(deq);
		end
	end

endmodule

// ===== design/rse_outq.sv =====
module rse_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  rse_pkg::res_t din,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output rse_pkg::res_t dout
);
	import rse_pkg::*;

	res_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = q_q[rd_ptr_q];
	assign rd    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= !wr_ptr_q;
			if (rd) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

// ===== design/rse_back.sv =====
module rse_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rse_pkg::PL_W-1:0]  program_length,
	input  logic                      head_valid,
	input  rse_pkg::dec_t             head,
	output logic                      deq,
	output logic                      clearing,
	input  logic                      res_full,
	output logic                      res_wr,
	output rse_pkg::res_t             res
);
	import rse_pkg::*;

	// register file, entry 31 is never written so it always reads zero
	logic [31:0]        rf_q [32];
	logic [31:0]        rf_vld_q;
	logic [31:0]        dm_q [MEM_WORDS];
	logic [31:0]        dm_rd_q;

	logic               clr_q;
	logic [MEM_AW-1:0]  clr_cnt_q;

	logic               ex_vld_q;
	dec_t               ex_q;
	logic [31:0]        opa_q;
	logic [31:0]        opb_q;
	logic               ex_wait_q;

	logic [PC_W-1:0]    pc_q;
	logic [31:0]        cyc_q;
	logic [31:0]        opcnt_q [NUM_OPS];

	logic [31:0]        b;
	logic [31:0]        addr;
	logic               addr_ok;
	status_t            st;
	logic               lw_first;
	logic               done;
	logic               ex_free;
	logic               commit;
	logic [31:0]        wval;
	logic [31:0]        prod;
	logic               take;
	logic [PC_W-1:0]    npc;
	logic [PC_W-1:0]    pc_nxt;
	logic               rf_we;
	logic               dm_we;
	logic [MEM_AW-1:0]  dm_wa;
	logic [31:0]        dm_wd;

	assign clearing = clr_q;

	always_comb begin
		b       = ex_q.use_reg ? opb_q : ex_q.imm;
		addr    = ex_q.use_reg ? (opa_q + ex_q.imm) : ex_q.imm;
		addr_ok = !addr[31] && (addr >= 32'(program_length)) && (addr < 32'(MEM_WORDS));
		// only the low word of the product is kept
		prod    = opa_q * b;

		priority if (!ex_q.known_op)                      st = ST_OK;
		else if (ex_q.writes_reg && ex_q.rd == ZERO_REG)  st = ST_ZERO_WRITE;
		else if ((ex_q.is_br || ex_q.is_j) && !ex_q.known) st = ST_NO_LABEL;
		else if (ex_q.is_mem && !addr_ok)                 st = ST_BAD_MEM;
		else                                              st = ST_OK;

		take = ((ex_q.op == OP_BEQ) == (opb_q == (ex_q.use_reg ? opa_q : ex_q.imm)));
		npc  = (ex_q.is_j || (ex_q.is_br && take)) ? ex_q.target : pc_q + 1'b1;

		unique case (ex_q.op)
			OP_ADD:  wval = opa_q + b;
			OP_ADDI: wval = opa_q + ex_q.imm;
			OP_SUB:  wval = opa_q - b;
			OP_MUL:  wval = prod;
			OP_SLT:  wval = {31'd0, $signed(opa_q) < $signed(b)};
			OP_LW:   wval = dm_rd_q;
			OP_SW:   wval = opb_q;
			default: wval = '0;
		endcase

		// a valid lw waits in execute for the data store read
		lw_first = ex_vld_q && ex_q.op == OP_LW && st == ST_OK && !ex_wait_q;
		done     = ex_vld_q && !lw_first && !res_full;
		ex_free  = !ex_vld_q || done;
		deq      = head_valid && ex_free && !clr_q;
		commit   = done && st == ST_OK && ex_q.known_op && ex_q.op != OP_LABEL;

		if (commit)
			pc_nxt = npc;
		else if (done && st == ST_OK && ex_q.op == OP_LABEL)
			pc_nxt = pc_q + 1'b1;
		else
			pc_nxt = pc_q;

		rf_we = commit && ex_q.writes_reg;
		dm_we = clr_q || (commit && ex_q.op == OP_SW);
		dm_wa = clr_q ? clr_cnt_q : addr[MEM_AW-1:0];
		dm_wd = clr_q ? '0 : opb_q;

		res_wr            = done;
		res.status        = st;
		res.next_pc       = pc_nxt;
		res.write_value   = commit ? wval : '0;
		res.cycle_total   = commit ? cyc_q + 1'b1 : cyc_q;
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[ex_q.rd] <= wval;
		end
		if (deq) begin
			ex_q <= head;
			if (rf_we && ex_q.rd == head.rs)
				opa_q <= wval;
			else
				opa_q <= rf_vld_q[head.rs] ? rf_q[head.rs] : '0;
			if (rf_we && ex_q.rd == head.rb)
				opb_q <= wval;
			else
				opb_q <= rf_vld_q[head.rb] ? rf_q[head.rb] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dm_q[dm_wa] <= dm_wd;
		end
		dm_rd_q <= dm_q[addr[MEM_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			ex_vld_q  <= 1'b0;
			ex_wait_q <= 1'b0;
			pc_q      <= '0;
			cyc_q     <= '0;
			for (int i = 0; i < NUM_OPS; i++) opcnt_q[i] <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q) clr_q <= 1'b0;
			end
			if (rf_we) rf_vld_q[ex_q.rd] <= 1'b1;
			if (deq)
				ex_vld_q <= 1'b1;
			else if (done)
				ex_vld_q <= 1'b0;
			if (lw_first)
				ex_wait_q <= 1'b1;
			else if (done)
				ex_wait_q <= 1'b0;
			pc_q <= pc_nxt;
			if (commit) begin
				cyc_q <= cyc_q + 1'b1;
				for (int i = 0; i < NUM_OPS; i++) begin
					if (ex_q.op == op_t'(OPC_W'(i))) opcnt_q[i] <= opcnt_q[i] + 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_no_exec_while_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !ex_vld_q && !deq)
		else $error("instruction issued during store clear");
	a_err_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(done && st != ST_OK) |=> pc_q == $past(pc_q) && cyc_q == $past(cyc_q))
		else $error("failed instruction changed state");
	a_lw_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		lw_first |=> ex_vld_q && ex_wait_q && $stable(ex_q))
		else $error("lw left execute before its read returned");
	a_zero_reg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!rf_vld_q[ZERO_REG])
		else $error("zero register written");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import rse_pkg::*;

	typedef struct packed {
		logic [3:0]  op;
		logic [4:0]  rd;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [31:0] imm;
		logic        use_reg;
		logic [11:0] target;
		logic        known;
	} instr_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [11:0] pc;
		logic [31:0] wval;
		logic [31:0] cyc;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [3:0] op = '0;
	logic [4:0] dest_reg = '0, src_reg = '0, third_reg = '0;
	logic signed [31:0] immediate = '0;
	logic use_register = 1'b0;
	logic [11:0] target_index = '0;
	logic target_known = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] status;
	logic [11:0] next_pc;
	logic signed [31:0] write_value;
	logic [31:0] cycle_total;

	risc_subset_execute_unit uut (.*);

	// shadow machine state
	logic [31:0] regs [32];
	logic [31:0] dmem [MEM_WORDS];
	logic [11:0] pc_q;
	logic [31:0] cyc_q;
	logic [12:0] prog_len;

	instr_t   pending [$];
	outcome_t expected_words [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle = 0, recv_stall = 0;
	int hold_pop = 0;
	bit timed_out = 0;

	// full as sampled at the last rising edge, so the driver knows what went in
	logic full_at_edge = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] reg_rd(logic [4:0] i);
		return (i == ZERO_REG) ? 32'd0 : regs[i];
	endfunction

	function automatic outcome_t execute(instr_t x);
		outcome_t r;
		logic [31:0] a, b, wv, addr, lhs, rhs;
		logic [11:0] npc;
		logic [1:0] st;
		logic wr;
		longint sa;
		a = reg_rd(x.rs);
		b = x.use_reg ? reg_rd(x.rt) : x.imm;
		wv = 0;
		st = ST_OK;
		sa = 0;
		wr = x.op inside {OP_ADD, OP_ADDI, OP_SUB, OP_MUL, OP_SLT, OP_LW};
		if (x.op > OP_LABEL) begin
		end else if (wr && x.rd == ZERO_REG) begin
			st = ST_ZERO_WRITE;
		end else if (x.op inside {OP_BEQ, OP_BNE, OP_J} && !x.known) begin
			st = ST_NO_LABEL;
		end else if (x.op == OP_LABEL) begin
			pc_q = pc_q + 12'd1;
		end else begin
			npc = pc_q + 12'd1;
			case (x.op)
				OP_ADD: wv = a + b;
				OP_ADDI: wv = a + x.imm;
				OP_SUB: wv = a - b;
				OP_MUL: wv = a * b;
				OP_SLT: wv = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				OP_BEQ, OP_BNE: begin
					lhs = reg_rd(x.rd);
					rhs = x.use_reg ? reg_rd(x.rs) : x.imm;
					if ((x.op == OP_BEQ) == (lhs == rhs))
						npc = x.target;
				end
				OP_J: npc = x.target;
				default: begin
					addr = x.use_reg ? a + x.imm : x.imm;
					sa = longint'($signed(addr));
					if (sa < longint'(prog_len) || sa >= MEM_WORDS)
						st = ST_BAD_MEM;
					else if (x.op == OP_LW)
						wv = dmem[sa];
					else
						wv = reg_rd(x.rd);
				end
			endcase
			if (st == ST_OK) begin
				if (wr)
					regs[x.rd] = wv;
				else if (x.op == OP_SW)
					dmem[sa] = wv;
				pc_q = npc;
				cyc_q = cyc_q + 1;
			end else begin
				wv = 0;
			end
		end
		r.st = st;
		r.pc = pc_q;
		r.wval = wv;
		r.cyc = cyc_q;
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		instr_t x;
		if (arst_n) begin
			if (push && !full_at_edge)
				void'(pending.pop_front());
			if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
				x = pending[0];
				push <= 1'b1;
				op <= x.op;
				dest_reg <= x.rd;
				src_reg <= x.rs;
				third_reg <= x.rt;
				immediate <= x.imm;
				use_register <= x.use_reg;
				target_index <= x.target;
				target_known <= x.known;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver, with its own count for long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_pop > 0) begin
				hold_pop <= hold_pop - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		full_at_edge <= full;
	end

	// monitor
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (push && !full)
				expected_words.push_back(execute(pending[0]));
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: st=%0d pc=%0d wv=%h cyc=%0d",
							status, next_pc, write_value, cycle_total);
				end else begin
					e = expected_words.pop_front();
					if (e.st !== status || e.pc !== next_pc || e.wval !== write_value
						|| e.cyc !== cycle_total) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d pc=%0d wv=%h cyc=%0d",
								e.st, e.pc, e.wval, e.cyc,
								" got st=%0d pc=%0d wv=%h cyc=%0d",
								status, next_pc, write_value, cycle_total);
					end
				end
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > 20000 && !timed_out) begin
				timed_out = 1;
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic apb_write(logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		prog_len = v[12:0];
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_words.size() > 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [4:0] pick_reg();
		// favour a few registers so values get reused
		return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(4));
	endfunction

	function automatic instr_t rand_instr();
		instr_t x;
		int k;
		x.op = ($urandom_range(49) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
		x.rd = pick_reg();
		if ($urandom_range(29) == 0) x.rd = ZERO_REG;
		x.rs = pick_reg();
		x.rt = pick_reg();
		x.use_reg = 1'($urandom);
		k = $urandom_range(3);
		case (k)
			0: x.imm = $urandom;
			1: x.imm = $urandom_range(8);
			2: x.imm = 32'($signed($urandom_range(40)) - 20);
			default: x.imm = $urandom_range(MEM_WORDS + 4);
		endcase
		if (x.op inside {OP_LW, OP_SW} && $urandom_range(3) != 0) begin
			x.imm = x.use_reg ? $urandom_range(64) : $urandom_range(MEM_WORDS - 1, prog_len);
			if (x.use_reg) x.rs = ZERO_REG;
		end
		x.target = 12'($urandom);
		x.known = ($urandom_range(9) != 0);
		return x;
	endfunction

	function automatic instr_t mk(logic [3:0] o, logic [4:0] d, logic [4:0] s, logic [4:0] t,
		logic [31:0] i, logic u, logic [11:0] tg, logic k);
		instr_t x;
		x.op = o; x.rd = d; x.rs = s; x.rt = t; x.imm = i;
		x.use_reg = u; x.target = tg; x.known = k;
		return x;
	endfunction

	task automatic run_random(int n);
		repeat (n) pending.push_back(rand_instr());
		drain();
	endtask

	initial begin
		foreach (regs[i]) regs[i] = 0;
		foreach (dmem[i]) dmem[i] = 0;
		pc_q = 0;
		cyc_q = 0;
		prog_len = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words
		pending.push_back(mk(OP_ADDI, 1, 31, 0, 32'h7fffffff, 0, 0, 1));
		pending.push_back(mk(OP_ADDI, 2, 1, 0, 32'd1, 0, 0, 1));
		pending.push_back(mk(OP_ADD, 3, 2, 2, 0, 1, 0, 1));
		pending.push_back(mk(OP_SUB, 4, 31, 1, 32'hffffffff, 1, 0, 1));
		pending.push_back(mk(OP_MUL, 5, 1, 1, 0, 1, 0, 1));
		pending.push_back(mk(OP_MUL, 6, 2, 0, 32'hffffffff, 0, 0, 1));
		pending.push_back(mk(OP_SLT, 7, 2, 1, 0, 1, 0, 1));
		pending.push_back(mk(OP_SLT, 8, 1, 0, 32'h80000000, 0, 0, 1));
		pending.push_back(mk(OP_ADD, 31, 1, 1, 0, 1, 0, 1));
		pending.push_back(mk(OP_LW, 31, 1, 1, 32'd5000, 0, 0, 1));
		pending.push_back(mk(OP_BEQ, 1, 1, 0, 0, 1, 12'hfff, 1));
		pending.push_back(mk(OP_BNE, 1, 0, 0, 32'h7fffffff, 0, 12'd3, 1));
		pending.push_back(mk(OP_BEQ, 1, 2, 0, 0, 1, 12'd9, 0));
		pending.push_back(mk(OP_J, 0, 0, 0, 0, 0, 12'd4095, 1));
		pending.push_back(mk(OP_J, 0, 0, 0, 0, 0, 12'd7, 0));
		pending.push_back(mk(OP_LABEL, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(OP_SW, 1, 31, 0, 32'd4095, 0, 0, 1));
		pending.push_back(mk(OP_LW, 9, 31, 0, 32'd4095, 0, 0, 1));
		pending.push_back(mk(OP_SW, 1, 31, 0, 32'd4096, 0, 0, 1));
		pending.push_back(mk(OP_LW, 9, 31, 0, 32'hffffffff, 1, 0, 1));
		pending.push_back(mk(OP_ADDI, 10, 31, 0, 32'd4000, 0, 0, 1));
		pending.push_back(mk(OP_SW, 2, 10, 0, 32'd95, 1, 0, 1));
		pending.push_back(mk(OP_LW, 11, 10, 0, 32'd95, 1, 0, 1));
		pending.push_back(mk(4'd15, 0, 0, 0, 0, 0, 0, 0));
		drain();

		run_random(120);
		apb_write(32'd4096);
		run_random(40);
		apb_write(32'd0);
		apb_write(32'd100);
		send_idle = 80;
		run_random(120);
		send_idle = 0;
		recv_stall = 80;
		run_random(120);
		apb_write(32'h1fff);
		send_idle = 28;
		recv_stall = 28;
		run_random(60);
		apb_write(32'd17);
		run_random(100);
		// long hold-off so the unit fills and stalls push
		send_idle = 0;
		recv_stall = 0;
		hold_pop = 60;
		run_random(80);
		drain();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
